>>> design/lav_pkg.sv
`timescale 1ns / 1ps
package lav_pkg;

   // Number format and port widths.
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 32;
   localparam int UNIT_W    = 18;
   localparam int SHIFT_W   = 48;

   // Vectors entering a normalizer: the widest is a cross product of a unit
   // vector and a raw input.
   localparam int PROD_W  = UNIT_W + IN_W;
   localparam int VEC_W   = PROD_W - 1;
   localparam int MSB_W   = $clog2(VEC_W);
   localparam int DOT_W   = PROD_W + 2;

   // Normalized magnitudes lie below 2^NORM_W, the sum of their squares below 2^SQ_W.
   localparam int NORM_W  = 30;
   localparam int SQ_W    = 2 * NORM_W + 2;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int REM_W   = ROOT_W + 4;

   // Divider: quotient bits and the numerator width.
   localparam int QB      = FRAC_BITS + 1;
   localparam int DEN_W   = ROOT_W;
   localparam int NUM_W   = NORM_W + QB;

   // Steps per pipeline stage of the root and divider chains.
   localparam int SQ_PER  = 2;
   localparam int SQ_ST   = (ROOT_W + SQ_PER - 1) / SQ_PER;
   localparam int DV_PER  = 2;
   localparam int DV_ST   = (QB + DV_PER - 1) / DV_PER;

   // Stage counts of the units and of the whole pipe.
   localparam int UNIT_LAT  = 7 + SQ_ST + DV_ST;
   localparam int CROSS_LAT = 2;
   localparam int DOT_LAT   = 3;
   localparam int T_F       = UNIT_LAT;
   localparam int T_R       = T_F + CROSS_LAT + UNIT_LAT;
   localparam int T_T       = T_R + CROSS_LAT + UNIT_LAT;
   localparam int TOTAL     = T_T + DOT_LAT;

   localparam logic [UNIT_W-1:0] UNIT_POS = UNIT_W'(1 << FRAC_BITS);

   typedef logic [2:0][IN_W-1:0]   lav_word3_type;
   typedef logic [2:0][VEC_W-1:0]  lav_vec_type;
   typedef logic [2:0][UNIT_W-1:0] lav_unit3_type;

   // Magnitudes and signs that ride along the root chain.
   typedef struct packed {
      logic                   zero;
      logic [2:0]             neg;
      logic [2:0][NORM_W-1:0] mag;
   } lav_side_type;

   typedef struct packed {
      lav_side_type      side;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [SQ_W-1:0]   rad;
   } lav_sqrt_type;

   typedef struct packed {
      logic                  zero;
      logic [2:0]            neg;
      logic [DEN_W-1:0]      den;
      logic [2:0][DEN_W-1:0] rem;
      logic [2:0][QB-1:0]    low;
      logic [2:0][QB-1:0]    quo;
   } lav_div_type;

endpackage

>>> design/lav_unit.sv
`timescale 1ns / 1ps
module lav_unit (
   input  logic                   clock,
   input  logic                   en,
   input  lav_pkg::lav_vec_type   vec_in,
   output lav_pkg::lav_unit3_type unit_out
);
   import lav_pkg::*;

   logic [2:0][VEC_W-1:0]  mag_in;
   logic [2:0]             neg_in;
   logic [VEC_W-1:0]       top_in;
   logic [2:0][VEC_W-1:0]  s1_mag_ff, s2_mag_ff;
   logic [2:0]             s1_neg_ff, s2_neg_ff;
   logic [VEC_W-1:0]       s1_top_ff;
   logic [MSB_W-1:0]       msb_in, s2_msb_ff, amt;
   logic                   s2_zero_ff, shift_right;
   lav_side_type           s3_in, s3_ff, s4_side_ff;
   logic [2:0][SQ_W-3:0]   s4_sq_ff;
   lav_sqrt_type           sq_ff [SQ_ST+1];
   lav_sqrt_type           sq_in [SQ_ST+1];
   lav_div_type            dv_ff [DV_ST+1];
   lav_div_type            dv_in [DV_ST+1];
   logic [2:0][NUM_W-1:0]  num;
   lav_unit3_type          unit_in, unit_ff;

   // Magnitudes, signs and the largest magnitude.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = vec_in[i][VEC_W-1];
         mag_in[i] = neg_in[i] ? VEC_W'(-vec_in[i]) : vec_in[i];
      end
      top_in = mag_in[0];
      if (mag_in[1] > top_in) begin
         top_in = mag_in[1];
      end
      if (mag_in[2] > top_in) begin
         top_in = mag_in[2];
      end
   end

   // Leading one of the largest magnitude.
   always_comb begin
      msb_in = '0;
      for (int j = 0; j < VEC_W; j++) begin
         if (s1_top_ff[j]) begin
            msb_in = MSB_W'(j);
         end
      end
   end

   // Shift all magnitudes by one amount so the largest lands in [2^29, 2^30).
   always_comb begin
      shift_right = s2_msb_ff >= MSB_W'(NORM_W - 1);
      amt = shift_right ? s2_msb_ff - MSB_W'(NORM_W - 1) : MSB_W'(NORM_W - 1) - s2_msb_ff;
      s3_in.zero = s2_zero_ff;
      s3_in.neg  = s2_neg_ff;
      for (int i = 0; i < 3; i++) begin
         s3_in.mag[i] = shift_right ? NORM_W'(s2_mag_ff[i] >> amt)
                                    : NORM_W'(s2_mag_ff[i] << amt);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mag_ff  <= mag_in;
         s1_neg_ff  <= neg_in;
         s1_top_ff  <= top_in;
         s2_mag_ff  <= s1_mag_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_msb_ff  <= msb_in;
         s2_zero_ff <= s1_top_ff == '0;
         s3_ff      <= s3_in;
         s4_side_ff <= s3_ff;
         for (int i = 0; i < 3; i++) begin
            s4_sq_ff[i] <= (SQ_W-2)'(s3_ff.mag[i] * s3_ff.mag[i]);
         end
      end
   end

   // Sum of squares opens the root chain.
   always_comb begin
      sq_in[0].side = s4_side_ff;
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      sq_in[0].rad  = SQ_W'(s4_sq_ff[0]) + SQ_W'(s4_sq_ff[1]) + SQ_W'(s4_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= sq_in[0];
      end
   end

   // Integer square root, two result bits per stage.
   for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
      lav_sqrt_type     st;
      logic [REM_W-1:0] rem2, trial;

      always_comb begin
         st    = sq_ff[k];
         rem2  = '0;
         trial = '0;
         for (int j = 0; j < SQ_PER; j++) begin
            if (k * SQ_PER + j < ROOT_W) begin
               rem2  = {st.rem[REM_W-3:0], st.rad[SQ_W-1 -: 2]};
               trial = {{(REM_W - ROOT_W - 2){1'b0}}, st.root, 2'b01};
               st.rad = {st.rad[SQ_W-3:0], 2'b00};
               if (rem2 >= trial) begin
                  st.rem  = rem2 - trial;
                  st.root = {st.root[ROOT_W-2:0], 1'b1};
               end else begin
                  st.rem  = rem2;
                  st.root = {st.root[ROOT_W-2:0], 1'b0};
               end
            end
         end
         sq_in[k+1] = st;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k+1] <= sq_in[k+1];
         end
      end
   end

   // Numerators with half the divisor added for rounding.
   always_comb begin
      dv_in[0].zero = sq_ff[SQ_ST].side.zero;
      dv_in[0].neg  = sq_ff[SQ_ST].side.neg;
      dv_in[0].den  = sq_ff[SQ_ST].root;
      for (int i = 0; i < 3; i++) begin
         num[i] = {sq_ff[SQ_ST].side.mag[i], {FRAC_BITS{1'b0}}}
                  + NUM_W'(sq_ff[SQ_ST].root >> 1);
         dv_in[0].rem[i] = DEN_W'(num[i][NUM_W-1:QB]);
         dv_in[0].low[i] = num[i][QB-1:0];
         dv_in[0].quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv_in[0];
      end
   end

   // Restoring division of the three components, two quotient bits per stage.
   for (genvar k = 0; k < DV_ST; k++) begin : g_div
      lav_div_type      st;
      logic [DEN_W:0]   r2;

      always_comb begin
         st = dv_ff[k];
         r2 = '0;
         for (int j = 0; j < DV_PER; j++) begin
            if (k * DV_PER + j < QB) begin
               for (int i = 0; i < 3; i++) begin
                  r2 = {st.rem[i], st.low[i][QB-1]};
                  st.low[i] = {st.low[i][QB-2:0], 1'b0};
                  if (r2 >= {1'b0, st.den}) begin
                     st.rem[i] = DEN_W'(r2 - {1'b0, st.den});
                     st.quo[i] = {st.quo[i][QB-2:0], 1'b1};
                  end else begin
                     st.rem[i] = DEN_W'(r2);
                     st.quo[i] = {st.quo[i][QB-2:0], 1'b0};
                  end
               end
            end
         end
         dv_in[k+1] = st;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k+1] <= dv_in[k+1];
         end
      end
   end

   // Clamp, apply signs and force a zero-length vector to zero.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_ff[DV_ST].zero) begin
            unit_in[i] = '0;
         end else if (UNIT_W'(dv_ff[DV_ST].quo[i]) > UNIT_POS) begin
            unit_in[i] = dv_ff[DV_ST].neg[i] ? UNIT_W'(-UNIT_POS) : UNIT_POS;
         end else if (dv_ff[DV_ST].neg[i]) begin
            unit_in[i] = UNIT_W'(-UNIT_W'(dv_ff[DV_ST].quo[i]));
         end else begin
            unit_in[i] = UNIT_W'(dv_ff[DV_ST].quo[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff <= unit_in;
      end
   end

   assign unit_out = unit_ff;

endmodule

>>> design/lav_cross.sv
`timescale 1ns / 1ps
module lav_cross (
   input  logic                   clock,
   input  logic                   en,
   input  lav_pkg::lav_unit3_type a_in,
   input  lav_pkg::lav_word3_type b_in,
   output lav_pkg::lav_vec_type   c_out
);
   import lav_pkg::*;

   logic signed [PROD_W-1:0] p_ff [6];
   logic signed [PROD_W:0]   d0, d1, d2;
   lav_vec_type              c_ff;

   // Six products, then the three differences.
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= $signed(a_in[1]) * $signed(b_in[2]);
         p_ff[1] <= $signed(a_in[2]) * $signed(b_in[1]);
         p_ff[2] <= $signed(a_in[2]) * $signed(b_in[0]);
         p_ff[3] <= $signed(a_in[0]) * $signed(b_in[2]);
         p_ff[4] <= $signed(a_in[0]) * $signed(b_in[1]);
         p_ff[5] <= $signed(a_in[1]) * $signed(b_in[0]);
      end
   end

   always_comb begin
      d0 = (PROD_W + 1)'(p_ff[0]) - (PROD_W + 1)'(p_ff[1]);
      d1 = (PROD_W + 1)'(p_ff[2]) - (PROD_W + 1)'(p_ff[3]);
      d2 = (PROD_W + 1)'(p_ff[4]) - (PROD_W + 1)'(p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff[0] <= d0[VEC_W-1:0];
         c_ff[1] <= d1[VEC_W-1:0];
         c_ff[2] <= d2[VEC_W-1:0];
      end
   end

   assign c_out = c_ff;

endmodule

>>> design/lav_dot.sv
`timescale 1ns / 1ps
module lav_dot (
   input  logic                   clock,
   input  logic                   en,
   input  logic                   negate,
   input  lav_pkg::lav_unit3_type u_in,
   input  lav_pkg::lav_word3_type e_in,
   output logic [lav_pkg::SHIFT_W-1:0] dot_out
);
   import lav_pkg::*;

   logic signed [PROD_W-1:0] p_ff [3];
   logic                     neg_ff;
   logic signed [DOT_W-1:0]  sum_in, sum_ff, rnd;
   logic [SHIFT_W-1:0]       dot_ff;

   // Products of the unit vector and the eye point.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= $signed(u_in[i]) * $signed(e_in[i]);
         end
         neg_ff <= negate;
      end
   end

   // Sum, with the sign flipped where asked.
   always_comb begin
      sum_in = DOT_W'(p_ff[0]) + DOT_W'(p_ff[1]) + DOT_W'(p_ff[2]);
      if (neg_ff) begin
         sum_in = -sum_in;
      end
   end

   // Round half up to the output fraction.
   always_comb begin
      rnd = (sum_ff + DOT_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
         dot_ff <= rnd[SHIFT_W-1:0];
      end
   end

   assign dot_out = dot_ff;

endmodule

>>> design/look_at_view_matrix.sv
`timescale 1ns / 1ps
// Look-at view matrix. Each request carries an eye point, a target point and an
// approximate up direction in signed Q16.16; the response gives the unit right,
// true up and back vectors in signed Q2.16 and the three translation entries in
// 48-bit Q32.16. A new request is taken in every cycle unless req_stall is high.
// The result comes from three normalizers in series, each with a square root
// pipeline of two bits per stage and a divider pipeline of two quotient bits
// per stage, plus the cross product and dot product stages. The pipeline moves
// as one, but it keeps moving while the last stage is empty, so gaps close up
// behind a stalled response. A zero-length vector normalizes to zero; when eye
// equals target all outputs are zero.
module look_at_view_matrix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lav_pkg::IN_W-1:0]    req_eye_x,
   input  logic [lav_pkg::IN_W-1:0]    req_eye_y,
   input  logic [lav_pkg::IN_W-1:0]    req_eye_z,
   input  logic [lav_pkg::IN_W-1:0]    req_target_x,
   input  logic [lav_pkg::IN_W-1:0]    req_target_y,
   input  logic [lav_pkg::IN_W-1:0]    req_target_z,
   input  logic [lav_pkg::IN_W-1:0]    req_upward_x,
   input  logic [lav_pkg::IN_W-1:0]    req_upward_y,
   input  logic [lav_pkg::IN_W-1:0]    req_upward_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_right_x,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_right_y,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_right_z,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_true_up_x,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_true_up_y,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_true_up_z,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_back_x,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_back_y,
   output logic [lav_pkg::UNIT_W-1:0]  rsp_back_z,
   output logic [lav_pkg::SHIFT_W-1:0] rsp_shift_x,
   output logic [lav_pkg::SHIFT_W-1:0] rsp_shift_y,
   output logic [lav_pkg::SHIFT_W-1:0] rsp_shift_z
);
   import lav_pkg::*;

   localparam int UP_D = T_F;
   localparam int EYE_D = T_T;
   localparam int FR_D = TOTAL - T_F;
   localparam int RT_D = TOTAL - T_R;
   localparam int TU_D = DOT_LAT;

   logic                  adv;
   logic                  v_ff [TOTAL+1];
   lav_word3_type         eye_ff, up_ff;
   logic [2:0][IN_W:0]    diff_ff;
   lav_vec_type           diff_vec;
   lav_word3_type         eye_dly_ff [EYE_D];
   lav_word3_type         up_dly_ff [UP_D];
   lav_unit3_type         front_dly_ff [FR_D];
   lav_unit3_type         right_dly_ff [RT_D];
   lav_unit3_type         tup_dly_ff [TU_D];
   lav_unit3_type         front, right, tup;
   lav_vec_type           cross_a, cross_b;
   lav_word3_type         front_wide;
   lav_word3_type         right_wide;
   logic [SHIFT_W-1:0]    sh_x, sh_y, sh_z;
   logic                  rsp_valid_ff, rsp_valid_in;
   lav_unit3_type         right_ff, tup_ff, back_ff;
   logic [2:0][SHIFT_W-1:0] shift_ff;

   // The pipe moves unless a finished result waits on a stalled response.
   assign adv       = !v_ff[TOTAL] || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Valid bits run alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= TOTAL; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int k = 1; k <= TOTAL; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // Request register and the exact target minus eye difference.
   always_ff @(posedge clock) begin
      if (adv) begin
         eye_ff <= {req_eye_z, req_eye_y, req_eye_x};
         up_ff  <= {req_upward_z, req_upward_y, req_upward_x};
         diff_ff[0] <= {req_target_x[IN_W-1], req_target_x} - {req_eye_x[IN_W-1], req_eye_x};
         diff_ff[1] <= {req_target_y[IN_W-1], req_target_y} - {req_eye_y[IN_W-1], req_eye_y};
         diff_ff[2] <= {req_target_z[IN_W-1], req_target_z} - {req_eye_z[IN_W-1], req_eye_z};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_vec[i]   = {{(VEC_W - IN_W - 1){diff_ff[i][IN_W]}}, diff_ff[i]};
         front_wide[i] = {{(IN_W - UNIT_W){front_dly_ff[T_R-T_F-1][i][UNIT_W-1]}},
                          front_dly_ff[T_R-T_F-1][i]};
         right_wide[i] = {{(IN_W - UNIT_W){right[i][UNIT_W-1]}}, right[i]};
      end
   end

   // Delay lines that keep operands aligned with the normalizers.
   always_ff @(posedge clock) begin
      if (adv) begin
         eye_dly_ff[0]   <= eye_ff;
         up_dly_ff[0]    <= up_ff;
         front_dly_ff[0] <= front;
         right_dly_ff[0] <= right;
         tup_dly_ff[0]   <= tup;
         for (int k = 1; k < EYE_D; k++) begin
            eye_dly_ff[k] <= eye_dly_ff[k-1];
         end
         for (int k = 1; k < UP_D; k++) begin
            up_dly_ff[k] <= up_dly_ff[k-1];
         end
         for (int k = 1; k < FR_D; k++) begin
            front_dly_ff[k] <= front_dly_ff[k-1];
         end
         for (int k = 1; k < RT_D; k++) begin
            right_dly_ff[k] <= right_dly_ff[k-1];
         end
         for (int k = 1; k < TU_D; k++) begin
            tup_dly_ff[k] <= tup_dly_ff[k-1];
         end
      end
   end

   // Front, right and true up, each through its own normalizer.
   lav_unit u_front (.clock(clock), .en(adv), .vec_in(diff_vec), .unit_out(front));

   lav_cross u_cross_fu (.clock(clock), .en(adv), .a_in(front),
                         .b_in(up_dly_ff[UP_D-1]), .c_out(cross_a));

   lav_unit u_right (.clock(clock), .en(adv), .vec_in(cross_a), .unit_out(right));

   lav_cross u_cross_rf (.clock(clock), .en(adv), .a_in(right),
                         .b_in(front_wide), .c_out(cross_b));

   lav_unit u_tup (.clock(clock), .en(adv), .vec_in(cross_b), .unit_out(tup));

   // Translation entries.
   lav_dot u_dot_x (.clock(clock), .en(adv), .negate(1'b1),
                    .u_in(right_dly_ff[T_T-T_R-1]), .e_in(eye_dly_ff[EYE_D-1]),
                    .dot_out(sh_x));

   lav_dot u_dot_y (.clock(clock), .en(adv), .negate(1'b1),
                    .u_in(tup), .e_in(eye_dly_ff[EYE_D-1]), .dot_out(sh_y));

   lav_dot u_dot_z (.clock(clock), .en(adv), .negate(1'b0),
                    .u_in(front_dly_ff[T_T-T_F-1]), .e_in(eye_dly_ff[EYE_D-1]),
                    .dot_out(sh_z));

   // Response register.
   always_comb begin
      if (adv && v_ff[TOTAL]) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v_ff[TOTAL]) begin
         right_ff <= right_dly_ff[RT_D-1];
         tup_ff   <= tup_dly_ff[TU_D-1];
         for (int i = 0; i < 3; i++) begin
            back_ff[i] <= UNIT_W'(-front_dly_ff[FR_D-1][i]);
         end
         shift_ff <= {sh_z, sh_y, sh_x};
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_right_x   = right_ff[0];
   assign rsp_right_y   = right_ff[1];
   assign rsp_right_z   = right_ff[2];
   assign rsp_true_up_x = tup_ff[0];
   assign rsp_true_up_y = tup_ff[1];
   assign rsp_true_up_z = tup_ff[2];
   assign rsp_back_x    = back_ff[0];
   assign rsp_back_y    = back_ff[1];
   assign rsp_back_z    = back_ff[2];
   assign rsp_shift_x   = shift_ff[0];
   assign rsp_shift_y   = shift_ff[1];
   assign rsp_shift_z   = shift_ff[2];

   // The request side stalls only behind a result in the last stage and a held response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v_ff[TOTAL] && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a held response");

   // A result leaving the pipe is always presented next cycle.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (adv && v_ff[TOTAL]) |=> rsp_valid)
      else $error("result lost at the response register");

   // The right x and back z components never exceed one in magnitude.
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_right_x) <= $signed(UNIT_POS)
                     && $signed(rsp_right_x) >= -$signed(UNIT_POS)
                     && $signed(rsp_back_z) <= $signed(UNIT_POS)
                     && $signed(rsp_back_z) >= -$signed(UNIT_POS)))
      else $error("unit component out of range");

   // With no front vector there is no right or true up either.
   a_zero_front: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_back_x == '0 && rsp_back_y == '0 && rsp_back_z == '0)
      |-> (rsp_right_x == '0 && rsp_right_y == '0 && rsp_right_z == '0
           && rsp_true_up_x == '0 && rsp_true_up_y == '0 && rsp_true_up_z == '0))
      else $error("basis vectors not zero for a zero front");

endmodule

>>> dv/look_at_view_checker.sv
`timescale 1ns / 1ps
module look_at_view_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [lav_pkg::IN_W-1:0]    req_eye_x,
   input  logic [lav_pkg::IN_W-1:0]    req_eye_y,
   input  logic [lav_pkg::IN_W-1:0]    req_eye_z,
   input  logic [lav_pkg::IN_W-1:0]    req_target_x,
   input  logic [lav_pkg::IN_W-1:0]    req_target_y,
   input  logic [lav_pkg::IN_W-1:0]    req_target_z,
   input  logic [lav_pkg::IN_W-1:0]    req_upward_x,
   input  logic [lav_pkg::IN_W-1:0]    req_upward_y,
   input  logic [lav_pkg::IN_W-1:0]    req_upward_z,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_right_x,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_right_y,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_right_z,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_true_up_x,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_true_up_y,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_true_up_z,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_back_x,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_back_y,
   input  logic [lav_pkg::UNIT_W-1:0]  rsp_back_z,
   input  logic [lav_pkg::SHIFT_W-1:0] rsp_shift_x,
   input  logic [lav_pkg::SHIFT_W-1:0] rsp_shift_y,
   input  logic [lav_pkg::SHIFT_W-1:0] rsp_shift_z,
   output int                          fail_count,
   output int                          pending_views
);
   import lav_pkg::*;

   typedef struct packed {
      logic [2:0][UNIT_W-1:0]  right;
      logic [2:0][UNIT_W-1:0]  tup;
      logic [2:0][UNIT_W-1:0]  back;
      logic [2:0][SHIFT_W-1:0] shift;
   } view_type;

   typedef longint signed vec3_type [3];

   view_type expected_views [$];

   assign pending_views = expected_views.size();

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Bring the largest into [2^29, 2^30), then divide by the rounded-down root.
   function automatic vec3_type normalize(vec3_type v);
      vec3_type u;
      longint unsigned m [3];
      longint unsigned top, sum, root, q;
      top = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? -v[i] : v[i];
         if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
         u[0] = 0; u[1] = 0; u[2] = 0;
         return u;
      end
      while (top >= (64'd1 << 30)) begin
         top >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (top < (64'd1 << 29)) begin
         top <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      root = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC_BITS) + (root >> 1)) / root;
         if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
         u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return u;
   endfunction

   function automatic vec3_type cross_prod(vec3_type a, vec3_type b);
      vec3_type c;
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      return c;
   endfunction

   function automatic longint signed dot_rounded(vec3_type a, vec3_type b, bit negate);
      longint signed d;
      d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      if (negate) d = -d;
      return (d + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic view_type compute_view(logic [2:0][IN_W-1:0] eye_w,
         logic [2:0][IN_W-1:0] tgt_w, logic [2:0][IN_W-1:0] up_w);
      vec3_type eye, up, dir, front, right, tup;
      view_type r;
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'($signed(eye_w[i]));
         up[i]  = longint'($signed(up_w[i]));
         dir[i] = longint'($signed(tgt_w[i])) - eye[i];
      end
      front = normalize(dir);
      right = normalize(cross_prod(front, up));
      tup   = normalize(cross_prod(right, front));
      for (int i = 0; i < 3; i++) begin
         r.right[i] = right[i][UNIT_W-1:0];
         r.tup[i]   = tup[i][UNIT_W-1:0];
         r.back[i]  = UNIT_W'(-front[i]);
      end
      r.shift[0] = SHIFT_W'(dot_rounded(right, eye, 1'b1));
      r.shift[1] = SHIFT_W'(dot_rounded(tup, eye, 1'b1));
      r.shift[2] = SHIFT_W'(dot_rounded(front, eye, 1'b0));
      return r;
   endfunction

   // Predict on each accepted request and compare each accepted response.
   always @(posedge clock) begin
      view_type got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_views.push_back(compute_view(
               {req_eye_z, req_eye_y, req_eye_x},
               {req_target_z, req_target_y, req_target_x},
               {req_upward_z, req_upward_y, req_upward_x}));
         if (rsp_valid && !rsp_stall) begin
            got.right = {rsp_right_z, rsp_right_y, rsp_right_x};
            got.tup   = {rsp_true_up_z, rsp_true_up_y, rsp_true_up_x};
            got.back  = {rsp_back_z, rsp_back_y, rsp_back_x};
            got.shift = {rsp_shift_z, rsp_shift_y, rsp_shift_x};
            if (expected_views.size() == 0) begin
               if (fail_count < 10) $display("unexpected response at %0t", $time);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_views.pop_front();
               if (got != want) begin
                  if (fail_count < 10) begin
                     $display("mismatch at %0t", $time);
                     for (int i = 0; i < 3; i++)
                        $display("  [%0d] right %h/%h up %h/%h back %h/%h shift %h/%h", i,
                           want.right[i], got.right[i], want.tup[i], got.tup[i],
                           want.back[i], got.back[i], want.shift[i], got.shift[i]);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> dv/tb_look_at_view_matrix.sv
`timescale 1ns / 1ps
module tb_look_at_view_matrix;
   import lav_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0][IN_W-1:0] eye = '0, tgt = '0, up = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [UNIT_W-1:0] right_x, right_y, right_z, tup_x, tup_y, tup_z;
   logic [UNIT_W-1:0] back_x, back_y, back_z;
   logic [SHIFT_W-1:0] shift_x, shift_y, shift_z;
   int fail_count, pending_views;
   int cycle_count = 0;
   bit hold_off = 0;
   bit stimulus_done = 0;

   always #4 clock = ~clock;

   look_at_view_matrix uut (
      .clock, .reset, .req_valid, .req_stall,
      .req_eye_x(eye[0]), .req_eye_y(eye[1]), .req_eye_z(eye[2]),
      .req_target_x(tgt[0]), .req_target_y(tgt[1]), .req_target_z(tgt[2]),
      .req_upward_x(up[0]), .req_upward_y(up[1]), .req_upward_z(up[2]),
      .rsp_valid, .rsp_stall,
      .rsp_right_x(right_x), .rsp_right_y(right_y), .rsp_right_z(right_z),
      .rsp_true_up_x(tup_x), .rsp_true_up_y(tup_y), .rsp_true_up_z(tup_z),
      .rsp_back_x(back_x), .rsp_back_y(back_y), .rsp_back_z(back_z),
      .rsp_shift_x(shift_x), .rsp_shift_y(shift_y), .rsp_shift_z(shift_z));

   look_at_view_checker checker_inst (
      .clock, .reset, .req_valid, .req_stall,
      .req_eye_x(eye[0]), .req_eye_y(eye[1]), .req_eye_z(eye[2]),
      .req_target_x(tgt[0]), .req_target_y(tgt[1]), .req_target_z(tgt[2]),
      .req_upward_x(up[0]), .req_upward_y(up[1]), .req_upward_z(up[2]),
      .rsp_valid, .rsp_stall,
      .rsp_right_x(right_x), .rsp_right_y(right_y), .rsp_right_z(right_z),
      .rsp_true_up_x(tup_x), .rsp_true_up_y(tup_y), .rsp_true_up_z(tup_z),
      .rsp_back_x(back_x), .rsp_back_y(back_y), .rsp_back_z(back_z),
      .rsp_shift_x(shift_x), .rsp_shift_y(shift_y), .rsp_shift_z(shift_z),
      .fail_count, .pending_views);

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("tb_look_at_view_matrix: done, errors");
         $finish;
      end
   end

   // Pick a coordinate: moderate values half the time, else small, full range or extremes.
   function automatic logic [IN_W-1:0] pick_coord();
      unique case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3: return $urandom();
         4: return $urandom_range(0, 7) - 3;
         default: return IN_W'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   // Send one request, with a random gap before it. Valid stays high between
   // requests that follow each other with no gap.
   task automatic send_view(logic [2:0][IN_W-1:0] e, logic [2:0][IN_W-1:0] t,
         logic [2:0][IN_W-1:0] u);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      eye <= e;
      tgt <= t;
      up <= u;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Response side: random stalls, plus one long hold-off while requests keep coming.
   initial begin
      int wait_cycles;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         wait_cycles = $urandom_range(0, 6);
         if (wait_cycles > 0 && !stimulus_done) begin
            rsp_stall <= 1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 0;
         @(negedge clock);
      end
   end

   initial begin
      logic [2:0][IN_W-1:0] e, t, u;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, eye equal to target, up parallel to front, zero up.
      send_view('0, '0, '0);
      send_view({3{32'h0001_0000}}, {3{32'h0001_0000}}, {32'h0, 32'h0001_0000, 32'h0});
      send_view('0, {32'h0, 32'h0, 32'hffff_0000}, {32'h0, 32'h0001_0000, 32'h0});
      send_view('0, {32'h0, 32'h0, 32'h0001_0000}, {32'h0, 32'h0, 32'h0003_0000});
      send_view('0, {32'h0, 32'h0002_0000, 32'h0}, '0);
      send_view({3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {32'h8000_0000, 32'h7fff_ffff, 32'h0});
      send_view({3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{32'h7fff_ffff}});
      send_view({3{32'h8000_0000}}, {3{32'h8000_0000}}, {3{32'hffff_ffff}});
      send_view({32'h1, 32'h0, 32'h0}, '0, {32'h1, 32'h0, 32'h0});
      send_view({32'h8000_0000, 32'h7fff_ffff, 32'h1}, {32'h7fff_ffff, 32'h8000_0000, 32'h0},
                {32'hffff_ffff, 32'h1, 32'h8000_0000});
      send_view({3{32'haaaa_aaaa}}, {3{32'h5555_5555}}, {3{32'hffff_ffff}});
      send_view({3{32'h5555_5555}}, {3{32'haaaa_aaaa}}, {3{32'h0001_0000}});

      // Random part, with a long response hold-off partway through.
      for (int n = 0; n < 1700; n++) begin
         if (n == 600) hold_off = 1;
         for (int i = 0; i < 3; i++) begin
            e[i] = pick_coord();
            t[i] = pick_coord();
            u[i] = pick_coord();
         end
         if ($urandom_range(0, 19) == 0) t = e;
         if ($urandom_range(0, 19) == 0)
            for (int i = 0; i < 3; i++) u[i] = IN_W'($signed(t[i]) - $signed(e[i]));
         if ($urandom_range(0, 29) == 0) u = '0;
         send_view(e, t, u);
      end
      req_valid <= 0;
      stimulus_done = 1;

      while (pending_views != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_look_at_view_matrix: done, clean");
      end else begin
         $display("tb_look_at_view_matrix: done, errors");
      end
      $finish;
   end
endmodule

>>> look_at_view_matrix.f
design/lav_pkg.sv
design/lav_unit.sv
design/lav_cross.sv
design/lav_dot.sv
design/look_at_view_matrix.sv
dv/look_at_view_checker.sv
dv/tb_look_at_view_matrix.sv
